/* hdl/assert_macros.svh */
// Shared assertion helpers; every check is clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/tdpt_pkg.sv */
package tdpt_pkg;

    localparam int CAND_W = 32;
    localparam int WIDTH  = 32;
    localparam int CNT_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int PC_W   = 4;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_D,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ADD2,
        OP_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_LT2,
        C_IS2,
        C_EVEN,
        C_CNT_NZ,
        C_D_GT_Q,
        C_R_ZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  op;
        logic  res_we;
        logic  res_val;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    localparam pc_t PC_IDLE      = 4'd0;
    localparam pc_t PC_LT2       = 4'd1;
    localparam pc_t PC_IS2       = 4'd2;
    localparam pc_t PC_EVEN      = 4'd3;
    localparam pc_t PC_DIV_START = 4'd4;
    localparam pc_t PC_DIV_STEP  = 4'd5;
    localparam pc_t PC_BOUND     = 4'd6;
    localparam pc_t PC_REM       = 4'd7;
    localparam pc_t PC_NEXT_D    = 4'd8;
    localparam pc_t PC_WAIT      = 4'd9;
    localparam pc_t PC_EMIT      = 4'd10;

    // Control store: a taken condition jumps to target, else fall through.
    function automatic ctrl_word_t ucode_rom(input pc_t pc);
        ctrl_word_t cw;
        begin
            case (pc)
                PC_IDLE:      cw = '{OP_LOAD,      1'b0, 1'b0, C_NO_INPUT, PC_IDLE};
                PC_LT2:       cw = '{OP_NONE,      1'b1, 1'b0, C_LT2,      PC_WAIT};
                PC_IS2:       cw = '{OP_NONE,      1'b1, 1'b1, C_IS2,      PC_WAIT};
                PC_EVEN:      cw = '{OP_INIT_D,    1'b1, 1'b0, C_EVEN,     PC_WAIT};
                PC_DIV_START: cw = '{OP_DIV_START, 1'b0, 1'b0, C_NEVER,    PC_IDLE};
                PC_DIV_STEP:  cw = '{OP_DIV_STEP,  1'b0, 1'b0, C_CNT_NZ,   PC_DIV_STEP};
                PC_BOUND:     cw = '{OP_NONE,      1'b1, 1'b1, C_D_GT_Q,   PC_WAIT};
                PC_REM:       cw = '{OP_NONE,      1'b1, 1'b0, C_R_ZERO,   PC_WAIT};
                PC_NEXT_D:    cw = '{OP_ADD2,      1'b0, 1'b0, C_ALWAYS,   PC_DIV_START};
                PC_WAIT:      cw = '{OP_NONE,      1'b0, 1'b0, C_OUT_BUSY, PC_WAIT};
                PC_EMIT:      cw = '{OP_EMIT,      1'b0, 1'b0, C_ALWAYS,   PC_IDLE};
                default:      cw = '{OP_NONE,      1'b0, 1'b0, C_ALWAYS,   PC_IDLE};
            endcase
            return cw;
        end
    endfunction

endpackage

/* hdl/trial_division_primality_test.sv */
// Trial-division primality tester.
// Source channel: src_valid / src_stall carry one candidate per beat. The
// block takes a beat only when its sequencer sits in its idle step, so one
// candidate is worked on at a time; src_stall is high otherwise.
// Result channel: dst_valid / dst_stall carry is_prime, one beat per candidate,
// held in an output register so the next candidate can be taken while a
// result waits.
// The sequencer settles 0 and 1, 2 and other even candidates directly, and
// after emitting a result returns to idle, ready for the next beat. An odd
// candidate walks the odd divisors from 3 upward to its square root; each
// divisor trial runs the bit-serial restoring divider that yields quotient
// and remainder together. Worst case at 32 bits is 32768 divisor trials.
// Reset puts the sequencer in its idle step and empties the output register.
// When the receiver stalls, a finished result waits in the sequencer until
// the output register frees up; no beat is dropped.
module trial_division_primality_test (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_stall,
    input  logic [tdpt_pkg::CAND_W-1:0] candidate,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output logic                        is_prime
);
    import tdpt_pkg::*;

    `include "assert_macros.svh"

    pc_t              pc_reg, pc_next;
    ctrl_word_t       cw;
    logic             cond_hit;
    logic             src_accept;

    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_reg, res_next;
    logic             dst_valid_reg, dst_valid_next;
    logic             is_prime_reg, is_prime_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_diff;
    logic             fits;

    assign cw         = ucode_rom(pc_reg);
    assign src_stall  = (pc_reg != PC_IDLE);
    assign src_accept = src_valid && !src_stall;
    assign dst_valid  = dst_valid_reg;
    assign is_prime   = is_prime_reg;

    // One restoring division step: bring in the next dividend bit.
    assign rem_sh   = {rem_reg, quo_reg[WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign fits     = !rem_diff[WIDTH];

    always_comb
    begin
        case (cw.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_ALWAYS:   cond_hit = 1'b1;
            C_NO_INPUT: cond_hit = !src_accept;
            C_LT2:      cond_hit = (n_reg < WIDTH'(2));
            C_IS2:      cond_hit = (n_reg == WIDTH'(2));
            C_EVEN:     cond_hit = !n_reg[0];
            C_CNT_NZ:   cond_hit = (cnt_reg != '0);
            C_D_GT_Q:   cond_hit = (d_reg > quo_reg);
            C_R_ZERO:   cond_hit = (rem_reg == '0);
            C_OUT_BUSY: cond_hit = dst_valid_reg && dst_stall;
            default:    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = cond_hit ? cw.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        n_next         = n_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_next       = cw.res_we ? cw.res_val : res_reg;
        is_prime_next  = is_prime_reg;
        dst_valid_next = dst_valid_reg && dst_stall;
        case (cw.op)
            OP_LOAD:
            begin
                if (src_accept)
                begin
                    n_next = WIDTH'(candidate);
                end
            end
            OP_INIT_D:
            begin
                d_next = WIDTH'(3);
            end
            OP_DIV_START:
            begin
                rem_next = '0;
                quo_next = n_reg;
                cnt_next = CNT_W'(WIDTH - 1);
            end
            OP_DIV_STEP:
            begin
                rem_next = fits ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_ADD2:
            begin
                d_next = d_reg + WIDTH'(2);
            end
            OP_EMIT:
            begin
                dst_valid_next = 1'b1;
                is_prime_next  = res_reg;
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    `AST_IMPL(a_rem_below_div, pc_reg == PC_DIV_STEP || pc_reg == PC_BOUND, rem_reg < d_reg)
    `AST_IMPL(a_div_odd, pc_reg == PC_DIV_START, d_reg[0] && (d_reg >= WIDTH'(3)))
    `AST_NEXT(a_n_hold, pc_reg != PC_IDLE, $stable(n_reg))
    `AST_IMPL(a_emit_src, $rose(dst_valid_reg), $past(pc_reg) == PC_EMIT)

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import tdpt_pkg::*;

    localparam int          CW          = CAND_W;
    localparam int unsigned RUN_LIMIT   = 3_000_000;
    localparam int unsigned HOLD_AT     = 25;
    localparam int unsigned HOLD_CYCLES = 2000;
    localparam int unsigned TAIL_CYCLES = 80;

    typedef enum logic [1:0] {
        IDLE_SLOW_SINK,
        IDLE_SLOW_SOURCE,
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed {
        logic [CW-1:0] cand;
        logic          verdict;
    } verdict_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b1;
    logic          src_valid = 1'b0;
    logic          src_stall;
    logic [CW-1:0] candidate = '0;
    logic          dst_valid;
    logic          dst_stall = 1'b0;
    logic          is_prime;

    logic [CW-1:0] pending_q [$];
    verdict_t      verdict_q [$];

    int unsigned   src_beats  = 0;
    int unsigned   mismatches = 0;
    int unsigned   cycle_cnt  = 0;
    int unsigned   hold_left  = 0;
    logic          hold_done  = 1'b0;
    idle_mode_t    idle_mode;
    int unsigned   src_idle_pct;
    int unsigned   dst_idle_pct;

    trial_division_primality_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .candidate (candidate),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .is_prime  (is_prime)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Odd trial divisors up to the square root, bound kept in 64 bits.
    function automatic logic prime_verdict(input logic [CW-1:0] cand);
        logic [63:0] mask;
        logic [63:0] n;
        logic [63:0] d;
        mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
        n = {{(64 - CW){1'b0}}, cand} & mask;
        if (n < 64'd2)
            return 1'b0;
        if (n[0] == 1'b0)
            return (n == 64'd2);
        for (d = 64'd3; d <= n / d; d = d + 64'd2)
        begin
            if (n % d == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    always_comb
    begin
        if (src_beats < 45)
            idle_mode = IDLE_SLOW_SINK;
        else if (src_beats < 90)
            idle_mode = IDLE_SLOW_SOURCE;
        else
            idle_mode = IDLE_NONE;
        case (idle_mode)
            IDLE_SLOW_SINK:
            begin
                src_idle_pct = 9;
                dst_idle_pct = 85;
            end
            IDLE_SLOW_SOURCE:
            begin
                src_idle_pct = 85;
                dst_idle_pct = 9;
            end
            default:
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
        endcase
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Source side: hold the beat while stalled, otherwise offer the next candidate.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                verdict_q.push_back('{cand: candidate, verdict: prime_verdict(candidate)});
                src_beats <= src_beats + 1;
            end
            if (!src_valid || !src_stall)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    src_valid <= 1'b1;
                    candidate <= pending_q.pop_front();
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side so the block backs up into its input.
    always @(posedge clk)
    begin
        if (!hold_done && src_beats == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        dst_stall <= (hold_left != 0) || ($urandom_range(0, 99) < dst_idle_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        verdict_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                flag_mismatch($sformatf("result is_prime=%0b with no candidate pending",
                                        is_prime));
            end
            else
            begin
                want = verdict_q.pop_front();
                if (is_prime !== want.verdict)
                    flag_mismatch($sformatf("candidate %0d: is_prime=%b, want %b",
                                            want.cand, is_prime, want.verdict));
            end
        end
    end

    initial
    begin : stimulus
        logic [CW-1:0] n;
        int unsigned   pick;
        int unsigned   fac;

        // Drive reset low after all processes are waiting, so the edge is seen.
        rst_n <= 1'b0;

        // Edge values, smallest primes, prime squares, all-ones and sign-bit patterns.
        pending_q.push_back(32'd0);
        pending_q.push_back(32'd1);
        pending_q.push_back(32'd2);
        pending_q.push_back(32'd3);
        pending_q.push_back(32'd4);
        pending_q.push_back(32'd5);
        pending_q.push_back(32'd9);
        pending_q.push_back(32'd15);
        pending_q.push_back(32'd25);
        pending_q.push_back(32'd49);
        pending_q.push_back(32'd97);
        pending_q.push_back(32'd121);
        pending_q.push_back(32'd65537);
        pending_q.push_back(32'd994009);
        pending_q.push_back(32'd1000003);
        pending_q.push_back(32'hFFFF_FFFF);
        pending_q.push_back(32'hFFFF_FFFE);
        pending_q.push_back(32'h8000_0000);
        pending_q.push_back(32'hAAAA_AAAA);
        pending_q.push_back(32'h5555_5555);

        // Keep odd candidates small or with a tiny factor so the divisor walk stays short.
        for (int i = 0; i < 80; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                n = $urandom_range(0, 4095);
            end
            else if (pick < 60)
            begin
                n = $urandom_range(4096, 262143) | 32'd1;
            end
            else if (pick < 80)
            begin
                n = $urandom() & ~32'd1;
            end
            else
            begin
                fac = 3 + 2 * $urandom_range(0, 2);
                n = $urandom_range(0, 32'hFFFF_FFFF / fac) * fac;
            end
            pending_q.push_back(n);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || src_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (verdict_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
